### sv/trte_pkg.sv
// Shared types and constants of the trajectory tracking error block.
`default_nettype none

package trte_pkg;

	localparam int JOINTS  = 7;
	localparam int ANGLE_W = 16;
	localparam int TIME_W  = 32;
	localparam int SLOT_W  = 9;
	localparam int SCALE_W = 16;
	localparam int ROWS_W  = 7;
	localparam int STEP_W  = 24;
	localparam int FRAC_W  = 12;
	localparam int ERR_W   = 24;
	localparam int JNUM_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;
	localparam int WT_W    = FRAC_W + 1;
	localparam int TGT_W   = ANGLE_W + FRAC_W;
	localparam int DIFF_W  = TGT_W + 1;
	localparam int PROD_W  = DIFF_W + SCALE_W + 1;
	localparam int RND_SH  = 20;
	localparam int ERR_MAX = (1 << (ERR_W - 1)) - 1;
	localparam int ERR_MIN = -(1 << (ERR_W - 1));

	typedef enum logic [1:0] {
		MODE_CHUNK  = 2'd0,
		MODE_ANCHOR = 2'd1,
		MODE_EVAL   = 2'd2
	} mode_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_SCALE       = 3'd0,
		CFG_CHUNK_READY = 3'd1,
		CFG_INDEXED     = 3'd2,
		CFG_ROWS        = 3'd3,
		CFG_STEP        = 3'd4,
		CFG_START       = 3'd5,
		CFG_ANCHOR      = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TGT_ZERO   = 2'd0,
		TGT_INTERP = 2'd1,
		TGT_ANCHOR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic               chunk_ready;
		logic               indexed;
		logic [ROWS_W-1:0]  rows;
		logic [STEP_W-1:0]  step;
		logic [TIME_W-1:0]  start;
		logic               anchor_present;
	} cfg_t;

	// Register values after reset: only indexed mode is on.
	localparam cfg_t CFG_RESET = cfg_t'({SCALE_W'(0), 1'b0, 1'b1, ROWS_W'(0), STEP_W'(0),
		TIME_W'(0), 1'b0});

	typedef struct packed {
		mode_t                            mode;
		logic [TIME_W-1:0]                now_time;
		logic [SLOT_W-1:0]                word_slot;
		logic [ANGLE_W-1:0]               word_value;
		logic [JOINTS-1:0][ANGLE_W-1:0]   joint_pos;
	} item_t;

endpackage

`default_nettype wire

### sv/trte_if.sv
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface trte_item_if import trte_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [TIME_W-1:0]         now_time;
	logic [SLOT_W-1:0]         word_slot;
	logic signed [ANGLE_W-1:0] word_value;
	logic signed [ANGLE_W-1:0] joint_pos_0;
	logic signed [ANGLE_W-1:0] joint_pos_1;
	logic signed [ANGLE_W-1:0] joint_pos_2;
	logic signed [ANGLE_W-1:0] joint_pos_3;
	logic signed [ANGLE_W-1:0] joint_pos_4;
	logic signed [ANGLE_W-1:0] joint_pos_5;
	logic signed [ANGLE_W-1:0] joint_pos_6;

	modport source (output valid, mode, now_time, word_slot, word_value, joint_pos_0,
		joint_pos_1, joint_pos_2, joint_pos_3, joint_pos_4, joint_pos_5, joint_pos_6,
		input ready);
	modport sink (input valid, mode, now_time, word_slot, word_value, joint_pos_0,
		joint_pos_1, joint_pos_2, joint_pos_3, joint_pos_4, joint_pos_5, joint_pos_6,
		output ready);
endinterface

interface trte_result_if import trte_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] joint_error;
	logic [JNUM_W-1:0]       joint_number;
	logic                    last_joint;

	modport source (output valid, joint_error, joint_number, last_joint, input ready);
	modport sink (input valid, joint_error, joint_number, last_joint, output ready);
endinterface

interface trte_cfg_if import trte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/trte_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module trte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 448,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

### sv/trte_cfg.sv
// Configuration register file written through the configuration channel.
`default_nettype none

module trte_cfg import trte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	trte_cfg_if.sink   wr,
	output cfg_t       regs
);

	cfg_t cfg_q;

	assign wr.ready = 1'b1;
	assign regs     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr.valid) begin
			unique case (cfg_reg_t'(wr.index))
				CFG_SCALE:       cfg_q.scale          <= wr.data[SCALE_W-1:0];
				CFG_CHUNK_READY: cfg_q.chunk_ready    <= wr.data[0];
				CFG_INDEXED:     cfg_q.indexed        <= wr.data[0];
				CFG_ROWS:        cfg_q.rows           <= wr.data[ROWS_W-1:0];
				CFG_STEP:        cfg_q.step           <= wr.data[STEP_W-1:0];
				CFG_START:       cfg_q.start          <= wr.data[TIME_W-1:0];
				CFG_ANCHOR:      cfg_q.anchor_present <= wr.data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/trte_index.sv
// Front pipeline: target selection and a one-bit-per-stage divider for the row index.
`default_nettype none

module trte_index import trte_pkg::*; #(
	parameter int MAX_ROWS = 64,
	localparam int QB = $clog2(MAX_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              regs,
	trte_item_if.sink         item,
	output logic              out_valid,
	input  logic              out_ready,
	output item_t             out_item,
	output kind_t             out_kind,
	output logic [QB-1:0]     out_lo,
	output logic [QB-1:0]     out_hi,
	output logic [FRAC_W-1:0] out_frac
);

	localparam int NS  = QB + FRAC_W;
	localparam int RW  = STEP_W + QB;
	localparam int CW  = (RW > TIME_W) ? RW : TIME_W;
	localparam int MRW = $clog2(MAX_ROWS + 1);
	localparam int RSW = (MRW > ROWS_W) ? MRW : ROWS_W;

	typedef struct packed {
		item_t             itm;
		kind_t             kind;
		logic [QB-1:0]     rowsm1;
		logic [TIME_W-1:0] d;
		logic [RW-1:0]     lim;
	} head_t;

	typedef struct packed {
		item_t         itm;
		kind_t         kind;
		logic [QB-1:0] rowsm1;
		logic          clamp;
		logic [RW-1:0] rem;
		logic [NS-1:0] quo;
	} div_t;

	item_t          in_itm;
	logic [RSW-1:0] rows_raw;
	logic [RSW-1:0] rows_sel;
	logic [QB-1:0]  rowsm1_c;
	logic [TIME_W:0] dsub;
	logic           usable;
	kind_t          kind_c;
	logic           adv;

	logic  v_s1;
	head_t h_s1;
	// Element k holds pipeline stage 2 + k.
	logic  v_s2  [0:NS];
	div_t  dv_s2 [0:NS];

	logic [QB-1:0] q_idx;

	assign adv        = !v_s2[NS] || out_ready;
	assign item.ready = adv;

	always_comb begin
		in_itm.mode         = mode_t'(item.mode);
		in_itm.now_time     = item.now_time;
		in_itm.word_slot    = item.word_slot;
		in_itm.word_value   = item.word_value;
		in_itm.joint_pos[0] = item.joint_pos_0;
		in_itm.joint_pos[1] = item.joint_pos_1;
		in_itm.joint_pos[2] = item.joint_pos_2;
		in_itm.joint_pos[3] = item.joint_pos_3;
		in_itm.joint_pos[4] = item.joint_pos_4;
		in_itm.joint_pos[5] = item.joint_pos_5;
		in_itm.joint_pos[6] = item.joint_pos_6;

		rows_raw = RSW'(regs.rows);
		rows_sel = (rows_raw > RSW'(MAX_ROWS)) ? RSW'(MAX_ROWS) : rows_raw;
		rowsm1_c = QB'(rows_sel - RSW'(1));
		dsub     = {1'b0, item.now_time} - {1'b0, regs.start};
		usable   = regs.indexed && (rows_sel >= RSW'(2)) && (regs.step != '0)
			&& !dsub[TIME_W];

		priority if (regs.scale == '0 || !regs.chunk_ready) begin
			kind_c = TGT_ZERO;
		end else if (usable) begin
			kind_c = TGT_INTERP;
		end else if (regs.anchor_present) begin
			kind_c = TGT_ANCHOR;
		end else begin
			kind_c = TGT_ZERO;
		end
	end

	// Stage 1: elapsed time and the time at which the last row is reached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1.itm    <= in_itm;
			h_s1.kind   <= kind_c;
			h_s1.rowsm1 <= rowsm1_c;
			h_s1.d      <= dsub[TIME_W-1:0];
			h_s1.lim    <= RW'(RW'(rowsm1_c) * RW'(regs.step));
		end
	end

	// Stage 2: clamp decision and divider setup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else if (adv) begin
			v_s2[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s2[0].itm    <= h_s1.itm;
			dv_s2[0].kind   <= h_s1.kind;
			dv_s2[0].rowsm1 <= h_s1.rowsm1;
			dv_s2[0].clamp  <= CW'(h_s1.d) >= CW'(h_s1.lim);
			dv_s2[0].rem    <= RW'(h_s1.d);
			dv_s2[0].quo    <= '0;
		end
	end

	// Restoring division: integer bits first, then the fraction bits.
	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [RW-1:0] cand;
		logic [RW-1:0] dvsr;
		logic          take;
		div_t          nxt;

		if (k < QB) begin : g_int
			assign cand = dv_s2[k].rem;
			assign dvsr = RW'(regs.step) << (QB - 1 - k);
		end else begin : g_frac
			assign cand = dv_s2[k].rem << 1;
			assign dvsr = RW'(regs.step);
		end

		assign take = cand >= dvsr;

		always_comb begin
			nxt             = dv_s2[k];
			nxt.rem         = take ? (cand - dvsr) : cand;
			nxt.quo[NS-1-k] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k+1] <= 1'b0;
			end else if (adv) begin
				v_s2[k+1] <= v_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s2[k+1] <= nxt;
			end
		end
	end

	assign q_idx     = dv_s2[NS].quo[NS-1:FRAC_W];
	assign out_valid = v_s2[NS];
	assign out_item  = dv_s2[NS].itm;
	assign out_kind  = dv_s2[NS].kind;
	assign out_lo    = dv_s2[NS].clamp ? dv_s2[NS].rowsm1 : q_idx;
	assign out_hi    = dv_s2[NS].clamp ? dv_s2[NS].rowsm1 : q_idx + QB'(1);
	assign out_frac  = dv_s2[NS].clamp ? '0 : dv_s2[NS].quo[FRAC_W-1:0];

endmodule

`default_nettype wire

### sv/trte_track.sv
// Joint sequencer, reference stores and the interpolate, scale and saturate pipeline.
`default_nettype none

module trte_track import trte_pkg::*; #(
	parameter int MAX_ROWS = 64,
	localparam int QB = $clog2(MAX_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              regs,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  kind_t             in_kind,
	input  logic [QB-1:0]     in_lo,
	input  logic [QB-1:0]     in_hi,
	input  logic [FRAC_W-1:0] in_frac,
	trte_result_if.source     result
);

	localparam int DEPTH = MAX_ROWS * JOINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [JNUM_W-1:0] JLAST = JNUM_W'(JOINTS - 1);
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(ERR_MAX);
	localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(ERR_MIN);
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (RND_SH - 1);

	typedef struct packed {
		item_t             itm;
		kind_t             kind;
		logic [AW-1:0]     lo_base;
		logic [AW-1:0]     hi_base;
		logic [FRAC_W-1:0] frac;
	} cur_t;

	cur_t              cur_q;
	logic              busy_q;
	logic [JNUM_W-1:0] jcnt_q;
	logic [ANGLE_W-1:0] anchor_q [0:JOINTS-1];

	logic is_eval, issue, done, adv, take_in;
	logic we, re;
	logic [ANGLE_W-1:0] rd_lo, rd_hi;

	// Beat stages.
	logic                      v_b1, v_b2, v_b3, v_b4, v_b5;
	logic [ANGLE_W-1:0]        pos_b1, pos_b2;
	logic [ANGLE_W-1:0]        anc_b1, anc_b2;
	kind_t                     kind_b1, kind_b2, kind_b3;
	logic [FRAC_W-1:0]         frac_b1;
	logic [JNUM_W-1:0]         jn_b1, jn_b2, jn_b3, jn_b4, jn_b5;
	logic                      lst_b1, lst_b2, lst_b3, lst_b4, lst_b5;
	logic signed [TGT_W-1:0]   plo_b2, phi_b2;
	logic signed [DIFF_W-1:0]  diff_b3;
	logic signed [PROD_W-1:0]  prod_b4;
	logic signed [ERR_W-1:0]   err_b5;

	logic [WT_W-1:0]          wlo;
	logic signed [TGT_W-1:0]  tgt_c;
	logic signed [DIFF_W-1:0] posx_c;
	logic signed [PROD_W-1:0] rnd_c;

	assign adv      = !v_b5 || result.ready;
	assign is_eval  = cur_q.itm.mode == MODE_EVAL;
	assign issue    = busy_q && is_eval;
	assign done     = busy_q && (!is_eval || (jcnt_q == JLAST && adv));
	assign in_ready = !busy_q || done;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			jcnt_q <= '0;
		end else begin
			if (take_in) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (take_in) begin
				jcnt_q <= '0;
			end else if (issue && adv) begin
				jcnt_q <= jcnt_q + JNUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cur_q.itm     <= in_item;
			cur_q.kind    <= in_kind;
			cur_q.lo_base <= AW'(AW'(in_lo) * AW'(JOINTS));
			cur_q.hi_base <= AW'(AW'(in_hi) * AW'(JOINTS));
			cur_q.frac    <= in_frac;
		end
	end

	// Loads write while they sit in the sequencer, so they stay ordered with reads.
	assign we = busy_q && cur_q.itm.mode == MODE_CHUNK
		&& (32'(cur_q.itm.word_slot) < 32'(DEPTH));
	assign re = issue && adv && cur_q.kind == TGT_INTERP;

	always_ff @(posedge clk) begin
		if (busy_q && cur_q.itm.mode == MODE_ANCHOR
			&& (32'(cur_q.itm.word_slot) < 32'(JOINTS))) begin
			anchor_q[cur_q.itm.word_slot[JNUM_W-1:0]] <= cur_q.itm.word_value;
		end
	end

	trte_ram #(
		.WIDTH (ANGLE_W),
		.DEPTH (DEPTH)
	) u_rows (
		.clk     (clk),
		.we      (we),
		.waddr   (AW'(cur_q.itm.word_slot)),
		.wdata   (cur_q.itm.word_value),
		.re      (re),
		.raddr_a (cur_q.lo_base + AW'(jcnt_q)),
		.raddr_b (cur_q.hi_base + AW'(jcnt_q)),
		.rdata_a (rd_lo),
		.rdata_b (rd_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
		end else if (adv) begin
			v_b1 <= issue;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
		end
	end

	always_comb begin
		wlo    = WT_W'(1 << FRAC_W) - WT_W'(frac_b1);
		posx_c = DIFF_W'($signed(pos_b2)) <<< FRAC_W;
		unique case (kind_b2)
			TGT_INTERP: tgt_c = plo_b2 + phi_b2;
			TGT_ANCHOR: tgt_c = TGT_W'($signed(anc_b2)) <<< FRAC_W;
			default:    tgt_c = '0;
		endcase
		// Round to nearest with ties upward, then saturate.
		rnd_c = (prod_b4 + RND_HALF) >>> RND_SH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// b1: joint operands; row words arrive from the RAM read register.
			pos_b1  <= cur_q.itm.joint_pos[jcnt_q];
			anc_b1  <= anchor_q[jcnt_q];
			kind_b1 <= cur_q.kind;
			frac_b1 <= cur_q.frac;
			jn_b1   <= jcnt_q;
			lst_b1  <= jcnt_q == JLAST;

			// b2: weighted row words.
			plo_b2  <= TGT_W'($signed(rd_lo)) * $signed(TGT_W'(wlo));
			phi_b2  <= TGT_W'($signed(rd_hi)) * $signed(TGT_W'(frac_b1));
			pos_b2  <= pos_b1;
			anc_b2  <= anc_b1;
			kind_b2 <= kind_b1;
			jn_b2   <= jn_b1;
			lst_b2  <= lst_b1;

			// b3: position minus target; a disabled term gives zero.
			diff_b3 <= (kind_b2 == TGT_ZERO) ? '0 : posx_c - DIFF_W'(tgt_c);
			kind_b3 <= kind_b2;
			jn_b3   <= jn_b2;
			lst_b3  <= lst_b2;

			// b4: scale.
			prod_b4 <= PROD_W'(diff_b3) * $signed(PROD_W'(regs.scale));
			jn_b4   <= jn_b3;
			lst_b4  <= lst_b3;

			// b5: output register.
			if (rnd_c > SAT_HI) begin
				err_b5 <= ERR_W'(SAT_HI);
			end else if (rnd_c < SAT_LO) begin
				err_b5 <= ERR_W'(SAT_LO);
			end else begin
				err_b5 <= ERR_W'(rnd_c);
			end
			jn_b5   <= jn_b4;
			lst_b5  <= lst_b4;
		end
	end

	assign result.valid        = v_b5;
	assign result.joint_error  = err_b5;
	assign result.joint_number = jn_b5;
	assign result.last_joint   = lst_b5;

endmodule

`default_nettype wire

### sv/trajectory_reference_tracking_error.sv
// Top level of the trajectory tracking error block.
`default_nettype none

// An evaluate item gives seven results: the joint sequencer reads the lower and upper
// reference words of one joint per cycle through the two read ports of the row memory
// and takes the next item as the last joint issues. Load items and unused modes pass at
// one per cycle. Result back-pressure stalls the joint reads; an evaluation holds loads.
// Items pass two setup stages, a divider resolving one quotient bit per stage, the
// sequencer and five arithmetic stages ending in the output register. Configuration
// writes are taken at any time but must only be made while the block is idle. Row
// memory contents are undefined until written; no clearing pass is made.
module trajectory_reference_tracking_error import trte_pkg::*; #(
	parameter int MAX_ROWS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	trte_item_if.sink     item,
	trte_result_if.source result,
	trte_cfg_if.sink      cfg
);

	localparam int QB = $clog2(MAX_ROWS);

	cfg_t              regs;
	logic              idx_valid;
	logic              idx_ready;
	item_t             idx_item;
	kind_t             idx_kind;
	logic [QB-1:0]     idx_lo;
	logic [QB-1:0]     idx_hi;
	logic [FRAC_W-1:0] idx_frac;

	trte_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (regs)
	);

	trte_index #(
		.MAX_ROWS (MAX_ROWS)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.item      (item),
		.out_valid (idx_valid),
		.out_ready (idx_ready),
		.out_item  (idx_item),
		.out_kind  (idx_kind),
		.out_lo    (idx_lo),
		.out_hi    (idx_hi),
		.out_frac  (idx_frac)
	);

	trte_track #(
		.MAX_ROWS (MAX_ROWS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (idx_valid),
		.in_ready (idx_ready),
		.in_item  (idx_item),
		.in_kind  (idx_kind),
		.in_lo    (idx_lo),
		.in_hi    (idx_hi),
		.in_frac  (idx_frac),
		.result   (result)
	);

endmodule

`default_nettype wire
